// ----- hdl/lcsr_pkg.sv -----
// Shared types and constants for the lossless context sample reconstruction block.
package lcsr_pkg;

  localparam int SAMPLE_BITS = 8;
  localparam int CTX_COUNT   = 365;
  localparam int CTX_BITS    = 9;
  localparam int MERR_BITS   = 9;

  localparam logic signed [7:0] C_MAX = 8'sd127;
  localparam logic signed [7:0] C_MIN = -8'sd128;
  localparam logic [7:0]        N_CAP = 8'd255;

  localparam logic [15:0] A_RESET = 16'd4;
  localparam logic [7:0]  N_RESET = 8'd1;

  localparam logic [7:0] T1_RESET = 8'd3;
  localparam logic [7:0] T2_RESET = 8'd7;
  localparam logic [7:0] T3_RESET = 8'd21;
  localparam logic [7:0] HC_RESET = 8'd64;

  typedef enum logic [1:0] {
    CFG_THRESHOLD_ONE   = 2'd0,
    CFG_THRESHOLD_TWO   = 2'd1,
    CFG_THRESHOLD_THREE = 2'd2,
    CFG_HALVING_COUNT   = 2'd3
  } cfg_reg_e;

  // Classified sample handed from the front to the back.
  typedef struct packed {
    logic [CTX_BITS-1:0]    ctx;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] pred;
    logic [MERR_BITS-1:0]   merr;
  } front_item_t;

  // One context table entry.
  typedef struct packed {
    logic [15:0]       a;
    logic signed [9:0] b;
    logic signed [7:0] c;
    logic [7:0]        n;
  } ctx_word_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [CTX_BITS-1:0]    ctx;
  } result_t;

endpackage

// ----- hdl/lossless_context_sample_reconstruct.sv -----
// Flow: an accepted request is registered in the middle queue, then issued into the back end's
// execute register with its context table read, and its result is pushed into the result queue.
// Throughput: one sample per cycle; the context table read-modify-write with one-entry
// forwarding sets that figure. Stalls when the result queue backs up and during the clearing pass.
// Reset: the configuration and control registers return to their defaults and a clearing pass
// writes every context table entry; full stays high during that pass.
module lossless_context_sample_reconstruct #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] left_sample_i,
  input  logic [7:0] above_sample_i,
  input  logic [7:0] above_left_sample_i,
  input  logic [7:0] above_right_sample_i,
  input  logic [8:0] mapped_error_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] sample_o,
  output logic [8:0] context_index_o
);
  import lcsr_pkg::*;

  logic [7:0] t1_q, t2_q, t3_q, hc_q;
  front_item_t front_item, mid_item;
  logic        mid_full, mid_empty, mid_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
  logic        out_push, out_full, clearing;
  result_t     back_result, out_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= T1_RESET;
      t2_q <= T2_RESET;
      t3_q <= T3_RESET;
      hc_q <= HC_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_THRESHOLD_ONE:   t1_q <= cfg_wdata_i;
        CFG_THRESHOLD_TWO:   t2_q <= cfg_wdata_i;
        CFG_THRESHOLD_THREE: t3_q <= cfg_wdata_i;
        CFG_HALVING_COUNT:   hc_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign full = mid_full || clearing;

  lcsr_front u_front (
    .left_sample_i       (left_sample_i),
    .above_sample_i      (above_sample_i),
    .above_left_sample_i (above_left_sample_i),
    .above_right_sample_i(above_right_sample_i),
    .mapped_error_i      (mapped_error_i),
    .t1_i                (t1_q),
    .t2_i                (t2_q),
    .t3_i                (t3_q),
    .item_o              (front_item)
  );

  lcsr_fifo #(
    .WIDTH($bits(front_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && !full),
    .data_i (front_item),
    .pop_i  (mid_pop),
    .data_o (mid_item),
    .empty_o(mid_empty),
    .full_o (mid_full),
    .count_o(mid_count)
  );

  lcsr_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .halving_count_i(hc_q),
    .item_i         (mid_item),
    .item_empty_i   (mid_empty || (mid_count == '0)),
    .item_pop_o     (mid_pop),
    .out_count_i    (out_count),
    .out_push_o     (out_push),
    .out_data_o     (back_result),
    .clearing_o     (clearing)
  );

  lcsr_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (back_result),
    .pop_i  (pop),
    .data_o (out_head),
    .empty_o(empty),
    .full_o (out_full),
    .count_o(out_count)
  );

  // The back end reserves room before issue, so a push never meets a full queue.
  assign sample_o        = out_full ? out_head.sample : out_head.sample;
  assign context_index_o = out_head.ctx;

endmodule

// ----- hdl/lcsr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lcsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/lcsr_fifo.sv -----
// Small synchronous queue built from registers.
module lcsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
      end
      count_q <= count_q + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// ----- hdl/lcsr_front.sv -----
// Front end: gradient quantization, context folding and edge predictor.
module lcsr_front (
  input  logic [7:0]                left_sample_i,
  input  logic [7:0]                above_sample_i,
  input  logic [7:0]                above_left_sample_i,
  input  logic [7:0]                above_right_sample_i,
  input  logic [8:0]                mapped_error_i,
  input  logic [7:0]                t1_i,
  input  logic [7:0]                t2_i,
  input  logic [7:0]                t3_i,
  output lcsr_pkg::front_item_t     item_o
);
  import lcsr_pkg::*;

  function automatic logic signed [3:0] quant(input logic signed [9:0] g,
                                              input logic [7:0] t1,
                                              input logic [7:0] t2,
                                              input logic [7:0] t3);
    logic signed [9:0] p1, p2, p3;
    p1 = $signed({2'b00, t1});
    p2 = $signed({2'b00, t2});
    p3 = $signed({2'b00, t3});
    if (g <= -p3)      quant = -4'sd4;
    else if (g <= -p2) quant = -4'sd3;
    else if (g <= -p1) quant = -4'sd2;
    else if (g < 0)    quant = -4'sd1;
    else if (g == 0)   quant = 4'sd0;
    else if (g < p1)   quant = 4'sd1;
    else if (g < p2)   quant = 4'sd2;
    else if (g < p3)   quant = 4'sd3;
    else               quant = 4'sd4;
  endfunction

  logic signed [9:0]  sa, sb, sc, sd;
  logic signed [3:0]  q0, q1, q2, f0, f1, f2;
  logic               neg;
  logic signed [10:0] ctx_s;
  logic [7:0]         mx, mn;
  logic [9:0]         mid;
  logic [7:0]         pred;

  assign sa = $signed({2'b00, left_sample_i});
  assign sb = $signed({2'b00, above_sample_i});
  assign sc = $signed({2'b00, above_left_sample_i});
  assign sd = $signed({2'b00, above_right_sample_i});

  always_comb begin
    q0  = quant(sd - sb, t1_i, t2_i, t3_i);
    q1  = quant(sb - sc, t1_i, t2_i, t3_i);
    q2  = quant(sc - sa, t1_i, t2_i, t3_i);
    neg = (q0 < 0) || ((q0 == 0) && ((q1 < 0) || ((q1 == 0) && (q2 < 0))));
    f0  = neg ? -q0 : q0;
    f1  = neg ? -q1 : q1;
    f2  = neg ? -q2 : q2;
    ctx_s = 11'sd81 * 11'(f0) + 11'sd9 * 11'(f1) + 11'(f2);

    mx  = (left_sample_i > above_sample_i) ? left_sample_i : above_sample_i;
    mn  = (left_sample_i < above_sample_i) ? left_sample_i : above_sample_i;
    mid = {2'b00, left_sample_i} + {2'b00, above_sample_i} - {2'b00, above_left_sample_i};
    if (above_left_sample_i >= mx)      pred = mn;
    else if (above_left_sample_i <= mn) pred = mx;
    else                                pred = mid[7:0];

    item_o.ctx  = ctx_s[CTX_BITS-1:0];
    item_o.neg  = neg;
    item_o.pred = pred;
    item_o.merr = mapped_error_i;
  end

endmodule

// ----- hdl/lcsr_back.sv -----
// Back end: context table read-modify-write, error unmapping, reconstruction and the reset clearing pass.
module lcsr_back #(
  parameter int OUT_DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [7:0]                     halving_count_i,
  input  lcsr_pkg::front_item_t          item_i,
  input  logic                           item_empty_i,
  output logic                           item_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count_i,
  output logic                           out_push_o,
  output lcsr_pkg::result_t              out_data_o,
  output logic                           clearing_o
);
  import lcsr_pkg::*;

  localparam int OCW = $clog2(OUT_DEPTH+1);

  logic                clr_q;
  logic [CTX_BITS-1:0] clr_cnt_q;
  logic                e_valid_q;
  front_item_t         e_item_q;
  logic                fwd_valid_q;
  logic [CTX_BITS-1:0] fwd_ctx_q;
  ctx_word_t           fwd_word_q;

  ctx_word_t           rd_word, cur, upd, ram_wdata;
  logic [$bits(ctx_word_t)-1:0] ram_rdata;
  logic                ram_we;
  logic [CTX_BITS-1:0] ram_waddr;

  logic signed [9:0]  px_s, err, err_out;
  logic [7:0]         px;
  logic signed [11:0] bval, nneg;
  logic [16:0]        asum;
  logic [9:0]         aerr;
  logic [8:0]         nval;
  logic               halve, inv;
  logic signed [7:0]  cnew;
  logic [8:0]         merr;
  logic signed [9:0]  sum_out;

  // Issue needs room in the result queue for both the item in flight and this one.
  assign item_pop_o = !clr_q && !item_empty_i &&
                      ((out_count_i + OCW'(e_valid_q)) < OCW'(OUT_DEPTH));
  assign clearing_o = clr_q;

  lcsr_ram #(
    .WIDTH($bits(ctx_word_t)),
    .DEPTH(CTX_COUNT)
  ) u_ctx_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(item_i.ctx),
    .rdata_o(ram_rdata)
  );

  assign rd_word = ctx_word_t'(ram_rdata);
  // The entry written at the edge of the read is not yet in the RAM output.
  assign cur = (fwd_valid_q && (fwd_ctx_q == e_item_q.ctx)) ? fwd_word_q : rd_word;

  always_comb begin
    merr = e_item_q.merr;
    px_s = $signed({2'b00, e_item_q.pred}) +
           (e_item_q.neg ? -10'(cur.c) : 10'(cur.c));
    if (px_s > 10'sd255)   px = 8'd255;
    else if (px_s < 0)     px = 8'd0;
    else                   px = px_s[7:0];

    inv = ({8'd0, cur.n} >= cur.a) &&
          ((12'(cur.b) <<< 1) <= -$signed({4'd0, cur.n}));
    if (inv) begin
      if (merr[0]) err = $signed({2'b00, merr[8:1]});
      else         err = -$signed({2'b00, merr[8:1]}) - 10'sd1;
    end else begin
      if (merr[0]) err = -$signed({1'b0, 9'({1'b0, merr[8:1]} + 9'd1)});
      else         err = $signed({2'b00, merr[8:1]});
    end

    aerr = err[9] ? 10'(-err) : 10'(err);
    bval = 12'(cur.b) + 12'(err);
    asum = {1'b0, cur.a} + {7'd0, aerr};
    if (asum > 17'd65535) asum = 17'd65535;
    nval  = {1'b0, cur.n};
    halve = (cur.n == halving_count_i) || (cur.n == N_CAP);
    if (halve) begin
      asum = asum >> 1;
      bval = bval >>> 1;
      nval = nval >> 1;
    end
    nval = nval + 9'd1;
    nneg = -$signed({3'd0, nval});
    cnew = cur.c;
    if (bval <= nneg) begin
      bval = bval + $signed({3'd0, nval});
      if (cur.c > C_MIN) cnew = cur.c - 8'sd1;
      if (bval <= nneg) bval = nneg + 12'sd1;
    end else if (bval > 0) begin
      bval = bval - $signed({3'd0, nval});
      if (cur.c < C_MAX) cnew = cur.c + 8'sd1;
      if (bval > 0) bval = 12'sd0;
    end
    upd.a = asum[15:0];
    upd.b = bval[9:0];
    upd.c = cnew;
    upd.n = nval[7:0];

    err_out = e_item_q.neg ? -err : err;
    sum_out = $signed({2'b00, px}) + err_out;
    out_data_o.sample = sum_out[7:0];
    out_data_o.ctx    = e_item_q.ctx;
  end

  assign out_push_o = e_valid_q;

  always_comb begin
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '{a: A_RESET, b: '0, c: '0, n: N_RESET};
    end else begin
      ram_we    = e_valid_q;
      ram_waddr = e_item_q.ctx;
      ram_wdata = upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      e_item_q <= item_i;
    end
    fwd_ctx_q  <= e_item_q.ctx;
    fwd_word_q <= upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      e_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == CTX_BITS'(CTX_COUNT-1)) begin
          clr_q <= 1'b0;
        end
      end
      e_valid_q   <= item_pop_o;
      fwd_valid_q <= e_valid_q;
    end
  end

endmodule
